// ===== hdl/dhkv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_pkg
// Shared types and constants of the double-hashed key/value table.
// ----------------------------------------------------------------------------
package dhkv_pkg;

  // Fixed widths of the request and response words.
  localparam int KEY_W    = 32;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 10;

  // Hash constants: h = h * 33 xor byte, seeded with 5381.
  localparam int unsigned DJB_SEED  = 5381;
  localparam int          DJB_SHIFT = 5;
  localparam int          BYTE_W    = 8;

  // The remainder unit retires one digit of this many bits per cycle.
  localparam int DIGIT_W = 4;

  typedef enum logic [STATUS_W-1:0] {
    STS_INSERTED  = 3'd0,
    STS_UPDATED   = 3'd1,
    STS_FOUND     = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_FULL      = 3'd4
  } status_e;

endpackage

// ===== hdl/dhkv_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_req_if
// Request channel: insert or lookup of one key, with its value.
// ----------------------------------------------------------------------------
interface dhkv_req_if import dhkv_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [KEY_W-1:0]  key;
  logic [DATA_W-1:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);

endinterface

// ===== hdl/dhkv_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_rsp_if
// Response channel: status, looked-up value and occupied slot count.
// ----------------------------------------------------------------------------
interface dhkv_rsp_if import dhkv_pkg::*; ();

  logic               valid;
  logic               ready;
  status_e            status;
  logic [DATA_W-1:0]  value_out;
  logic [TOTAL_W-1:0] entry_total;

  modport source (output valid, output status, output value_out, output entry_total,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_total,
                  output ready);

endinterface

// ===== hdl/dhkv_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dhkv_rem_unit
// Iterative remainder unit: reduces a left-aligned dividend modulo a divisor,
// one digit per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module dhkv_rem_unit import dhkv_pkg::*; #(
  parameter int DIV_W = 20,
  parameter int REM_W = 10,
  parameter int CNT_W = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [REM_W-1:0] divisor_i,
  input  logic [CNT_W-1:0] digits_i,
  output logic             done_o,
  output logic [REM_W-1:0] rem_o
);

  localparam int ACC_W = REM_W + DIGIT_W;

  logic [DIV_W-1:0] dq_q;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [REM_W-1:0] dv_q;
  logic [CNT_W-1:0] cnt_q;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] sub;

  // Shift the next digit in, then take out up to 15 divisors, largest first.
  always_comb begin
    acc = {rem_q, dq_q[DIV_W-1 -: DIGIT_W]};
    sub = '0;
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      sub = ACC_W'(dv_q) << j;
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    rem_d = acc[REM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= digits_i;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (cnt_q != '0) begin
      dq_q  <= dq_q << DIGIT_W;
      rem_q <= rem_d;
    end
  end

  assign done_o = (cnt_q == '0);
  assign rem_o  = rem_q;

  a_rem_below_divisor : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (rem_q < dv_q))
    else $error("partial remainder reached the divisor");

  a_start_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> (cnt_q == '0))
    else $error("remainder unit restarted while busy");

endmodule

// ===== hdl/double_hash_key_value_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_key_value_table
// Open-addressed key/value table with double hashing over a slot memory.
// ----------------------------------------------------------------------------
// Usage:
// Each word on req_i is an insert (req_type 0) or a lookup (req_type 1) of a
// 32-bit key. Every request gives exactly one word on rsp_o with the status,
// the stored value of a found lookup (zero otherwise) and the number of
// occupied slots after the request.
// A request runs through a small sequencer: djb2 hashing of the key bytes,
// then the home slot is reduced modulo TABLE_SLOTS and, to form the probe
// step, modulo STEP_PRIME (the step again modulo TABLE_SLOTS when STEP_PRIME
// is not below it) in a shared remainder unit that retires four bits per
// cycle, then the slot memory is probed one slot at a time (only the home
// slot without collisions) and the result is registered for the response.
// A new request is taken only after the previous one has been handed to
// the output register.
// req_i.ready is high only while the sequencer is idle. The response sits in
// an output register, so the next request is accepted while the previous
// response still waits; a stalled receiver holds the finished result of that
// next request until the output register is taken.
// After reset the slot memory is cleared, one slot per cycle; no request is
// accepted during that sweep.
// ----------------------------------------------------------------------------
module double_hash_key_value_table import dhkv_pkg::*; #(
  parameter int TABLE_SLOTS = 1021,
  parameter int KEY_BYTES   = 4,
  parameter int STEP_PRIME  = 13,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dhkv_req_if.sink    req_i,
  dhkv_rsp_if.source  rsp_o
);

  // Hash magnitude: the seed fits 13 bits and each byte step grows it by
  // less than six bits, so the hash never wraps for up to eight key bytes.
  localparam int HASH_W  = 13 + 6 * KEY_BYTES;
  localparam int HNIB    = (HASH_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DW      = HNIB * DIGIT_W;
  localparam int IDX_W   = $clog2(TABLE_SLOTS);
  localparam int INIB    = (IDX_W + DIGIT_W - 1) / DIGIT_W;
  localparam int IDX_SH  = DW - INIB * DIGIT_W;
  localparam int STEP_W  = $clog2(STEP_PRIME + 1);
  localparam int SNIB    = (STEP_W + DIGIT_W - 1) / DIGIT_W;
  localparam int STEP_SH = DW - SNIB * DIGIT_W;
  localparam int DIVMAX  = (TABLE_SLOTS > STEP_PRIME) ? TABLE_SLOTS : STEP_PRIME;
  localparam int REM_W   = $clog2(DIVMAX + 1);
  localparam int NC_W    = $clog2(HNIB + 1);
  localparam int CNT_W   = $clog2(TABLE_SLOTS + 1);
  localparam int BCNT_W  = $clog2(KEY_BYTES + 1);
  localparam int VW      = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int WORD_W  = 1 + KEY_W + VW;
  // A step can exceed the slot count only when the prime is not below it;
  // the step then needs its own pass through the remainder unit.
  localparam bit STEP_WRAP = (STEP_PRIME >= TABLE_SLOTS);
  localparam logic [IDX_W:0] SLOTS_EXT = (IDX_W + 1)'(TABLE_SLOTS);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_HASH  = 8'b0000_0100,
    ST_MODH  = 8'b0000_1000,
    ST_MODP  = 8'b0001_0000,
    ST_MODS  = 8'b0010_0000,
    ST_PROBE = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Request registers.
  logic              lookup_q, lookup_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [KEY_W-1:0]  key_sh_q, key_sh_d;
  logic [VW-1:0]     val_q, val_d;
  logic [DW-1:0]     h_q, h_d, h_next;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d;

  // Probe walk.
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  d_q, d_d;
  logic [IDX_W-1:0]  step_m_q, step_m_d;
  logic [CNT_W-1:0]  vc_q, vc_d;
  logic [IDX_W:0]    idx_sum, d_sum;
  logic [IDX_W-1:0]  idx_adv, d_adv;
  logic [STEP_W-1:0] step_val;

  // Occupancy and sweep.
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  clr_q, clr_d;

  // Pending and presented result.
  status_e             res_status_q, res_status_d;
  logic [DATA_W-1:0]   res_value_q, res_value_d;
  logic                rsp_valid_q, rsp_valid_d;
  status_e             rsp_status_q, rsp_status_d;
  logic [DATA_W-1:0]   rsp_value_q, rsp_value_d;
  logic [TOTAL_W-1:0]  rsp_total_q, rsp_total_d;

  // Slot memory: used flag, key and value in one word.
  logic [WORD_W-1:0] slot_mem_q [TABLE_SLOTS];
  logic [WORD_W-1:0] rd_word_q;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_word;
  logic              rd_used;
  logic [KEY_W-1:0]  rd_key;
  logic [VW-1:0]     rd_val;
  logic              slot_hit;
  logic              last_visit;

  // Remainder unit hookup.
  logic              u_start;
  logic [DW-1:0]     u_dividend;
  logic [REM_W-1:0]  u_divisor;
  logic [NC_W-1:0]   u_digits;
  logic              u_done;
  logic [REM_W-1:0]  u_rem;

  dhkv_rem_unit #(
    .DIV_W (DW),
    .REM_W (REM_W),
    .CNT_W (NC_W)
  ) u_rem_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (u_start),
    .dividend_i (u_dividend),
    .divisor_i  (u_divisor),
    .digits_i   (u_digits),
    .done_o     (u_done),
    .rem_o      (u_rem)
  );

  // One djb2 step: h * 33 xor the next key byte. Bytes past the key's
  // width come out of the shifter as zero.
  assign h_next = ((h_q << DJB_SHIFT) + h_q) ^ DW'(key_sh_q[BYTE_W-1:0]);

  // Step is the prime minus the home slot modulo the prime, never zero.
  assign step_val = STEP_W'(STEP_PRIME) - u_rem[STEP_W-1:0];

  // Next probe: index advances by step*n, and step*n by step, both mod slots.
  assign idx_sum = {1'b0, idx_q} + {1'b0, d_q};
  assign d_sum   = {1'b0, d_q} + {1'b0, step_m_q};
  assign idx_adv = (idx_sum >= SLOTS_EXT) ? IDX_W'(idx_sum - SLOTS_EXT) : idx_sum[IDX_W-1:0];
  assign d_adv   = (d_sum >= SLOTS_EXT) ? IDX_W'(d_sum - SLOTS_EXT) : d_sum[IDX_W-1:0];

  assign rd_used    = rd_word_q[WORD_W-1];
  assign rd_key     = rd_word_q[VW +: KEY_W];
  assign rd_val     = rd_word_q[VW-1:0];
  assign slot_hit   = !rd_used || (rd_key == key_q);
  assign last_visit = (vc_q == CNT_W'(TABLE_SLOTS));

  always_comb begin
    state_d      = state_q;
    lookup_d     = lookup_q;
    key_d        = key_q;
    key_sh_d     = key_sh_q;
    val_d        = val_q;
    h_d          = h_q;
    bcnt_d       = bcnt_q;
    idx_d        = idx_q;
    d_d          = d_q;
    step_m_d     = step_m_q;
    vc_d         = vc_q;
    count_d      = count_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_value_d  = rsp_value_q;
    rsp_total_d  = rsp_total_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_word      = {1'b1, key_q, val_q};
    u_start      = 1'b0;
    u_dividend   = h_next;
    u_divisor    = REM_W'(TABLE_SLOTS);
    u_digits     = NC_W'(HNIB);

    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_word = '0;
        if (clr_q == IDX_W'(TABLE_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_i.valid) begin
          lookup_d = req_i.req_type;
          key_d    = req_i.key;
          key_sh_d = req_i.key;
          val_d    = VW'(req_i.value);
          h_d      = DW'(DJB_SEED);
          bcnt_d   = BCNT_W'(KEY_BYTES);
          state_d  = ST_HASH;
        end
      end
      ST_HASH: begin
        h_d      = h_next;
        key_sh_d = key_sh_q >> BYTE_W;
        bcnt_d   = bcnt_q - 1'b1;
        if (bcnt_q == BCNT_W'(1)) begin
          // Last byte: the finished hash goes straight into the unit.
          u_start = 1'b1;
          state_d = ST_MODH;
        end
      end
      ST_MODH: begin
        if (u_done) begin
          idx_d      = u_rem[IDX_W-1:0];
          u_start    = 1'b1;
          u_dividend = DW'(u_rem[IDX_W-1:0]) << IDX_SH;
          u_divisor  = REM_W'(STEP_PRIME);
          u_digits   = NC_W'(INIB);
          state_d    = ST_MODP;
        end
      end
      ST_MODP: begin
        if (u_done) begin
          vc_d = CNT_W'(1);
          if (STEP_WRAP) begin
            u_start    = 1'b1;
            u_dividend = DW'(step_val) << STEP_SH;
            u_digits   = NC_W'(SNIB);
            state_d    = ST_MODS;
          end else begin
            step_m_d = IDX_W'(step_val);
            d_d      = IDX_W'(step_val);
            state_d  = ST_PROBE;
          end
        end
      end
      ST_MODS: begin
        if (u_done) begin
          step_m_d = u_rem[IDX_W-1:0];
          d_d      = u_rem[IDX_W-1:0];
          state_d  = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (slot_hit || last_visit) begin
          res_value_d = '0;
          state_d     = ST_RESP;
          if (lookup_q) begin
            if (slot_hit && rd_used) begin
              res_status_d = STS_FOUND;
              res_value_d  = DATA_W'(rd_val);
            end else begin
              res_status_d = STS_NOT_FOUND;
            end
          end else if (!slot_hit) begin
            res_status_d = STS_FULL;
          end else if (rd_used) begin
            res_status_d = STS_UPDATED;
            wr_en        = 1'b1;
          end else begin
            res_status_d = STS_INSERTED;
            wr_en        = 1'b1;
            count_d      = count_q + 1'b1;
          end
        end else begin
          idx_d = idx_adv;
          d_d   = d_adv;
          vc_d  = vc_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = res_status_q;
          rsp_value_d  = res_value_q;
          rsp_total_d  = TOTAL_W'(count_q);
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      bcnt_q      <= '0;
      vc_q        <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      bcnt_q      <= bcnt_d;
      vc_q        <= vc_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lookup_q     <= lookup_d;
    key_q        <= key_d;
    key_sh_q     <= key_sh_d;
    val_q        <= val_d;
    h_q          <= h_d;
    idx_q        <= idx_d;
    d_q          <= d_d;
    step_m_q     <= step_m_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    rsp_status_q <= rsp_status_d;
    rsp_value_q  <= rsp_value_d;
    rsp_total_q  <= rsp_total_d;
  end

  // The read address follows the next probe index, so the slot word is
  // ready in the cycle the sequencer checks it.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem_q[wr_addr] <= wr_word;
    end
    rd_word_q <= slot_mem_q[idx_d];
  end

  assign req_i.ready       = (state_q == ST_IDLE);
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.value_out   = rsp_value_q;
  assign rsp_o.entry_total = rsp_total_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_SLOTS))
    else $error("occupied slot count exceeds the table size");

  a_probe_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |->
      ({1'b0, idx_q} < SLOTS_EXT) && ({1'b0, d_q} < SLOTS_EXT) && (step_m_q != '0))
    else $error("probe index or stride out of range");

  a_count_changes_in_probe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_PROBE) |=> $stable(count_q))
    else $error("slot count changed outside a probe decision");

endmodule

// ===== verif/double_hash_key_value_table_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_key_value_table_test
// Self-checking bench for the double-hashed key/value table: directed
// corner words, a random insert/lookup mix and a fill of one key's whole
// probe walk, with every response checked against an in-bench model of the
// slot store.
// ----------------------------------------------------------------------------
module double_hash_key_value_table_test import dhkv_pkg::*; ;

  // Request kinds carried in req_type.
  localparam bit OP_INSERT = 1'b0;
  localparam bit OP_LOOKUP = 1'b1;

  // Number of random words in the mixed phase, and the cap on the random
  // keys tried while filling the probe walk of the target key.
  localparam int MIX_WORDS  = 360;
  localparam int FILL_LIMIT = 100000;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps a private copy of the slot store, works out the
  // response of every accepted request word and checks the responses in
  // order against those predictions.
  // --------------------------------------------------------------------------
  class table_scoreboard;
    localparam int SLOTS      = 1021;
    localparam int STEP_PRIME = 13;
    localparam int KEY_BYTES  = 4;

    typedef struct packed {
      status_e            status;
      logic [DATA_W-1:0]  value_out;
      logic [TOTAL_W-1:0] entry_total;
    } outcome_t;

    bit                occupied[SLOTS];
    bit                on_path[SLOTS];
    bit [KEY_W-1:0]    slot_keys[SLOTS];
    bit [DATA_W-1:0]   slot_data[SLOTS];
    bit [TOTAL_W-1:0]  live_entries;
    outcome_t          pending_q[$];
    int unsigned       mismatch_count;

    // djb2 in its xor form over the key bytes, low byte first, then the
    // remainder by the slot count.
    function int unsigned home_of(bit [KEY_W-1:0] key_v);
      bit [63:0] h;
      bit [7:0]  octet;
      h = 64'(DJB_SEED);
      for (int i = 0; i < KEY_BYTES; i++) begin
        octet = (i < 4) ? key_v[8*i +: 8] : 8'd0;
        h = (h * 64'd33) ^ {56'd0, octet};
      end
      return int'(h % 64'(SLOTS));
    endfunction

    // Marks every slot that the walk of a key visits and returns how many
    // of those slots are still empty.
    function int unsigned mark_path(bit [KEY_W-1:0] key_v);
      int unsigned idx;
      int unsigned stride;
      int unsigned gaps;
      idx    = home_of(key_v);
      stride = STEP_PRIME - (idx % STEP_PRIME);
      gaps   = 0;
      foreach (on_path[i]) on_path[i] = 1'b0;
      for (int unsigned n = 1; n <= SLOTS; n++) begin
        if (!on_path[idx]) begin
          on_path[idx] = 1'b1;
          if (!occupied[idx]) gaps++;
        end
        idx = (idx + stride * n) % SLOTS;
      end
      return gaps;
    endfunction

    function void note_request(bit lookup, bit [KEY_W-1:0] key_v, bit [DATA_W-1:0] data_v);
      int unsigned idx;
      int unsigned stride;
      bit          hit;
      outcome_t    o;
      idx    = home_of(key_v);
      stride = STEP_PRIME - (idx % STEP_PRIME);
      hit    = 1'b0;
      // Probe until an empty slot or the same key turns up, with at most as many
      // visits as there are slots.
      for (int unsigned n = 1; n <= SLOTS; n++) begin
        if (!occupied[idx] || slot_keys[idx] == key_v) begin
          hit = 1'b1;
          break;
        end
        idx = (idx + stride * n) % SLOTS;
      end
      o.value_out = '0;
      if (lookup) begin
        if (hit && occupied[idx]) begin
          o.status    = STS_FOUND;
          o.value_out = slot_data[idx];
        end else begin
          o.status = STS_NOT_FOUND;
        end
      end else if (!hit) begin
        o.status = STS_FULL;
      end else if (occupied[idx]) begin
        slot_data[idx] = data_v;
        o.status       = STS_UPDATED;
      end else begin
        occupied[idx]  = 1'b1;
        slot_keys[idx] = key_v;
        slot_data[idx] = data_v;
        live_entries++;
        o.status = STS_INSERTED;
      end
      o.entry_total = live_entries;
      pending_q.push_back(o);
    endfunction

    task report(string msg);
      $display("[%0t] response error: %s", $realtime, msg);
      mismatch_count++;
    endtask

    task check_response(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] data_v,
                        logic [TOTAL_W-1:0] total_v);
      outcome_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("response word with no request waiting, status %0d", st));
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, predicted %0d", st, e.status));
      if (data_v !== e.value_out)
        report($sformatf("value_out %h, predicted %h", data_v, e.value_out));
      if (total_v !== e.entry_total)
        report($sformatf("entry_total %0d, predicted %0d", total_v, e.entry_total));
    endtask

    function int open_count();
      return pending_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Receiver side ready, held in a register of the bench.
  logic take_q = 1'b0;
  // While set, neither side inserts idle cycles.
  bit   calm   = 1'b0;
  int   stall_left = 0;

  table_scoreboard book = new();

  dhkv_req_if req_bus ();
  dhkv_rsp_if rsp_bus ();

  assign rsp_bus.ready = take_q;

  double_hash_key_value_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Sends one request word. Outside calm stretches a random burst of idle
  // cycles may come first; valid is only lowered for such a burst, so
  // back-to-back words keep it high without a glitch in the same step.
  // The word is booked with the scoreboard at the edge that accepts it.
  task automatic put_word(input bit lookup, input bit [KEY_W-1:0] key_v,
                          input bit [DATA_W-1:0] data_v);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    req_bus.valid    <= 1'b1;
    req_bus.req_type <= lookup;
    req_bus.key      <= key_v;
    req_bus.value    <= data_v;
    @(posedge clk_i);
    while (req_bus.ready !== 1'b1) @(posedge clk_i);
    book.note_request(lookup, key_v, data_v);
  endtask

  // Response side: every accepted word is checked at the edge that takes
  // it. Ready drops in random bursts except during calm stretches.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid === 1'b1 && take_q)
        book.check_response(rsp_bus.status, rsp_bus.value_out, rsp_bus.entry_total);
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        take_q <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 4);
        take_q <= 1'b0;
      end else begin
        take_q <= 1'b1;
      end
    end
  end

  initial begin
    bit [KEY_W-1:0] twins[$];
    bit [KEY_W-1:0] stored_keys[$];
    bit [KEY_W-1:0] fresh;
    bit [KEY_W-1:0] target;
    int unsigned    home_target;
    int unsigned    pick;
    int unsigned    gaps;
    int             attempts;

    req_bus.valid    <= 1'b0;
    req_bus.req_type <= OP_INSERT;
    req_bus.key      <= '0;
    req_bus.value    <= '0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words. The block clears its slot memory after reset and
    // holds ready low meanwhile, so the first word simply waits.
    // A lookup on the empty table, then both extreme keys with both
    // extreme values, inserted, read back and overwritten.
    put_word(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    put_word(OP_INSERT, 32'h0000_0000, 32'h0000_0000);
    put_word(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_word(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    put_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    put_word(OP_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    put_word(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    put_word(OP_INSERT, 32'hFFFF_FFFF, 32'h0000_0000);
    put_word(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);

    // Keys that share one home slot force probe walks of growing length.
    home_target = book.home_of(32'h1234_5678);
    twins.push_back(32'h1234_5678);
    fresh = 32'h1234_5679;
    while (twins.size() < 5) begin
      if (book.home_of(fresh) == home_target) twins.push_back(fresh);
      fresh = fresh + 1;
    end
    for (int i = 0; i < 4; i++) put_word(OP_INSERT, twins[i], $urandom);
    put_word(OP_LOOKUP, twins[3], 32'h0);
    put_word(OP_LOOKUP, twins[4], 32'h0);
    put_word(OP_INSERT, twins[2], 32'hA5A5_A5A5);
    put_word(OP_LOOKUP, twins[2], 32'h0);

    // Single-bit keys and alternating data patterns.
    put_word(OP_INSERT, 32'h8000_0000, 32'h5A5A_5A5A);
    put_word(OP_INSERT, 32'h0000_0001, 32'hA5A5_A5A5);
    put_word(OP_LOOKUP, 32'h8000_0000, 32'h0);
    put_word(OP_LOOKUP, 32'h0000_0001, 32'h0);
    for (int i = 0; i < 5; i++) stored_keys.push_back(twins[i]);

    // Random mix. Insert-heavy so the table keeps filling, with updates and
    // lookups aimed mostly at keys that are already stored. Every third
    // stretch of words runs without idle cycles.
    for (int i = 0; i < MIX_WORDS; i++) begin
      calm = ((i / 120) % 3) == 2;
      pick = $urandom_range(0, 99);
      if (stored_keys.size() == 0 || pick < 40) begin
        fresh = ($urandom_range(0, 7) == 0) ? KEY_W'($urandom_range(0, 1023)) : $urandom;
        stored_keys.push_back(fresh);
        put_word(OP_INSERT, fresh, $urandom);
      end else if (pick < 55) begin
        put_word(OP_INSERT, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                 $urandom);
      end else if (pick < 85) begin
        put_word(OP_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                 $urandom);
      end else begin
        put_word(OP_LOOKUP, $urandom, $urandom);
      end
    end

    // Last part, without idling: every slot on the probe walk of one target
    // key is filled by keys that land on their home slot, so inserting the
    // target runs into the probe bound.
    calm = 1'b1;
    target = $urandom;
    gaps = book.mark_path(target);
    attempts = 0;
    while (gaps > 0 && attempts < FILL_LIMIT) begin
      fresh = $urandom;
      pick  = book.home_of(fresh);
      if (book.on_path[pick] && !book.occupied[pick]) begin
        stored_keys.push_back(fresh);
        put_word(OP_INSERT, fresh, $urandom);
        gaps--;
      end
      attempts++;
    end

    // The target finds no free slot, and its lookup walks the whole bound.
    put_word(OP_INSERT, target, $urandom);
    put_word(OP_LOOKUP, target, 32'h0);

    // Random lookups, and stored keys are still found and can still be
    // updated.
    for (int i = 0; i < 12; i++) begin
      put_word(OP_LOOKUP, $urandom, $urandom);
      put_word(OP_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() / 2)], 32'h0);
      put_word(OP_INSERT, stored_keys[$urandom_range(0, stored_keys.size() / 2)],
               $urandom);
    end
    req_bus.valid <= 1'b0;

    // Drain the outstanding responses, then keep the clock running to show
    // any stray word.
    while (book.open_count() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);

    if (book.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
